/* sv/nalx_pkg.sv */
// Shared types and constants for the Annex B NAL unit extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package nalx_pkg;

	// Result kinds carried on the output channel.
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;

	// Byte values that steer the parser.
	localparam logic [7:0] BYTE_ZERO       = 8'h00;
	localparam logic [7:0] BYTE_START_TAIL = 8'h01;
	localparam logic [7:0] BYTE_EMULATION  = 8'h03;

	// Header field masks.
	localparam logic [7:0] MASK_FORBIDDEN = 8'h80;
	localparam logic [7:0] MASK_REF_IDC   = 8'h60;
	localparam logic [7:0] MASK_UNIT_TYPE = 8'h1f;

	// Most results that one input beat can cause.
	localparam int MAX_RESULTS = 3;

	// Parser modes.
	typedef enum logic [1:0] {
		MODE_HUNT    = 2'd0,
		MODE_HEADER  = 2'd1,
		MODE_PAYLOAD = 2'd2
	} mode_t;

	// One result before the header fields are split out.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} result_t;

	// All results caused by one input beat, in delivery order.
	typedef struct packed {
		logic [1:0]                   count;
		result_t [MAX_RESULTS-1:0]    res;
	} bundle_t;

endpackage

`default_nettype wire

/* sv/nalx_parse.sv */
// Input register and start-code / emulation-prevention parser.
// Depends on nalx_pkg; hands one bundle of up to three results per beat.
`default_nettype none

module nalx_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             req_type,
	input  wire logic [7:0]       stream_byte,
	output logic                  bundle_valid,
	output nalx_pkg::bundle_t     bundle,
	input  wire logic             bundle_take
);
	import nalx_pkg::*;

	logic       valid_s1;
	logic       flush_s1;
	logic [7:0] byte_s1;
	mode_t      mode_q, mode_d;
	logic [1:0] zrun_q, zrun_d;
	logic       consume;
	logic       is_zero, is_start, long_run, drop_emu;
	logic [1:0] held;
	logic [1:0] zrun_bump;

	// A beat leaves the input register when its bundle is empty or taken.
	assign consume      = valid_s1 && ((bundle.count == 2'd0) || bundle_take);
	assign in_stall     = valid_s1 && !consume;
	assign bundle_valid = valid_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			flush_s1 <= req_type;
			byte_s1  <= stream_byte;
		end
	end

	// Byte classification used by the two decode blocks.
	assign is_zero   = (byte_s1 == BYTE_ZERO);
	assign long_run  = zrun_q[1];
	assign is_start  = (byte_s1 == BYTE_START_TAIL) && long_run;
	assign drop_emu  = (byte_s1 == BYTE_EMULATION) && long_run;
	assign held      = long_run ? 2'd2 : {1'b0, zrun_q[0]};
	assign zrun_bump = (zrun_q == 2'd3) ? 2'd3 : zrun_q + 2'd1;

	// Next mode and zero-run count.
	always_comb begin
		mode_d = mode_q;
		zrun_d = zrun_q;
		if (flush_s1) begin
			mode_d = MODE_HUNT;
			zrun_d = 2'd0;
		end else begin
			case (mode_q)
				MODE_HEADER: begin
					mode_d = MODE_PAYLOAD;
					zrun_d = 2'd0;
				end
				MODE_PAYLOAD: begin
					if (is_zero) begin
						zrun_d = zrun_bump;
					end else if (is_start) begin
						mode_d = MODE_HEADER;
						zrun_d = 2'd0;
					end else begin
						zrun_d = 2'd0;
					end
				end
				default: begin
					if (is_zero) begin
						zrun_d = zrun_bump;
					end else if (is_start) begin
						mode_d = MODE_HEADER;
						zrun_d = 2'd0;
					end else begin
						mode_d = MODE_HUNT;
						zrun_d = 2'd0;
					end
				end
			endcase
		end
	end

	// Results caused by the registered beat.
	always_comb begin
		bundle.count = 2'd0;
		for (int i = 0; i < MAX_RESULTS; i++) begin
			bundle.res[i].kind = KIND_PAYLOAD;
			bundle.res[i].data = BYTE_ZERO;
		end
		if (flush_s1) begin
			if (mode_q == MODE_PAYLOAD) begin
				bundle.count       = 2'd1;
				bundle.res[0].kind = KIND_END;
			end
		end else begin
			case (mode_q)
				MODE_HEADER: begin
					bundle.count       = 2'd1;
					bundle.res[0].kind = KIND_HEADER;
					bundle.res[0].data = byte_s1;
				end
				MODE_PAYLOAD: begin
					if (is_zero) begin
						bundle.count = 2'd0;
					end else if (is_start) begin
						bundle.count       = 2'd1;
						bundle.res[0].kind = KIND_END;
					end else if (drop_emu) begin
						bundle.count = held;
					end else begin
						bundle.count          = held + 2'd1;
						bundle.res[held].data = byte_s1;
					end
				end
				default: begin
					bundle.count = 2'd0;
				end
			endcase
		end
	end

	// Parser state advances once per consumed beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			zrun_q <= 2'd0;
		end else if (consume) begin
			mode_q <= mode_d;
			zrun_q <= zrun_d;
		end
	end

endmodule

`default_nettype wire

/* sv/nalx_emit.sv */
// Result register that serializes one bundle into output beats.
// Depends on nalx_pkg; splits header fields out of the header byte.
`default_nettype none

module nalx_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             bundle_valid,
	input  wire nalx_pkg::bundle_t bundle,
	output logic                  bundle_take,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [1:0]            kind,
	output logic [7:0]            data_byte,
	output logic                  forbidden_bit,
	output logic [1:0]            ref_idc,
	output logic [4:0]            unit_type,
	output logic                  last_of_run
);
	import nalx_pkg::*;

	logic    bvalid_q;
	logic [1:0] idx_q;
	bundle_t bundle_q;
	result_t cur;
	logic    is_last;
	logic    out_fire;
	logic    load;

	assign cur      = bundle_q.res[idx_q];
	assign is_last  = (idx_q == bundle_q.count - 2'd1);
	assign out_fire = bvalid_q && !out_stall;

	// A new bundle may enter when the register is empty or on its final beat.
	assign bundle_take = !bvalid_q || (out_fire && is_last);
	assign load        = bundle_take && bundle_valid && (bundle.count != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= 2'd0;
		end else if (load) begin
			bvalid_q <= 1'b1;
			idx_q    <= 2'd0;
		end else if (out_fire) begin
			if (is_last) begin
				bvalid_q <= 1'b0;
				idx_q    <= 2'd0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bundle_q <= bundle;
		end
	end

	// Output fields; header fields are zero outside header beats.
	always_comb begin
		out_valid     = bvalid_q;
		kind          = cur.kind;
		data_byte     = cur.data;
		last_of_run   = is_last;
		forbidden_bit = 1'b0;
		ref_idc       = 2'd0;
		unit_type     = 5'd0;
		if (cur.kind == KIND_HEADER) begin
			forbidden_bit = |(cur.data & MASK_FORBIDDEN);
			ref_idc       = 2'((cur.data & MASK_REF_IDC) >> 5);
			unit_type     = 5'(cur.data & MASK_UNIT_TYPE);
		end
	end

endmodule

`default_nettype wire

/* sv/annexb_nal_unit_extractor.sv */
// Annex B NAL unit extractor: input register, parser, serializing result register.
// A byte is held in the input register, then its results in the result register.
// Throughput: one byte per cycle while out_stall is low and each byte causes at
// most one result; a byte with k results holds the output register for k beats.
// Reset: asynchronous, active low; hunting for a start code, zero run cleared.
// Depends on nalx_pkg, nalx_parse and nalx_emit.
`default_nettype none

module annexb_nal_unit_extractor (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       req_type,
	input  wire logic [7:0] stream_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte,
	output logic            forbidden_bit,
	output logic [1:0]      ref_idc,
	output logic [4:0]      unit_type,
	output logic            last_of_run
);
	import nalx_pkg::*;

	logic    bundle_valid;
	bundle_t bundle;
	logic    bundle_take;

	// Start-code hunt and emulation-prevention removal.
	nalx_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.stream_byte  (stream_byte),
		.bundle_valid (bundle_valid),
		.bundle       (bundle),
		.bundle_take  (bundle_take)
	);

	// One result beat per cycle out of the current bundle while out_stall is low.
	nalx_emit u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.bundle_valid  (bundle_valid),
		.bundle        (bundle),
		.bundle_take   (bundle_take),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.forbidden_bit (forbidden_bit),
		.ref_idc       (ref_idc),
		.unit_type     (unit_type),
		.last_of_run   (last_of_run)
	);

endmodule

`default_nettype wire
